/* hw/rtl/tpa_pkg.sv */
// Shared constants and types for the triangle perimeter/area pipeline.
// No dependencies.
`default_nettype none

package tpa_pkg;

  // Default vertex coordinate format
  localparam int COORD_BITS_DEF = 16;
  localparam int COORD_FRAC_DEF = 4;

  // Side lengths and area carry 8 fraction bits
  localparam int SIDE_FRAC = 8;
  // 16*s(s-a)(s-b)(s-c) has 4*SIDE_FRAC fraction bits and a factor of 16;
  // shifting by this leaves area^2 with 2*SIDE_FRAC fraction bits
  localparam int HERON_SHIFT = 4 * SIDE_FRAC - 2 * SIDE_FRAC + 4;

  localparam int RESULT_W = 32;

  // Operation codes
  localparam logic OP_PERIMETER = 1'b0;
  localparam logic OP_AREA      = 1'b1;

  // Sideband carried alongside the Heron product through the area root
  typedef struct packed {
    logic                func;
    logic                clamp;
    logic [RESULT_W-1:0] perim;
  } tpa_tag_t;

endpackage

`default_nettype wire

/* hw/rtl/tpa_isqrt.sv */
// Pipelined integer square root, one root bit per stage, several lanes
// sharing one valid bit and one sideband tag. No package dependencies.
`default_nettype none

module tpa_isqrt #(
  parameter int RAD_W = 41,
  parameter int LANES = 1,
  parameter int TAG_W = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [RAD_W-1:0]           in_rad [LANES],
  input  wire logic [TAG_W-1:0]           in_tag,
  output logic                            out_valid,
  output logic [(RAD_W+1)/2-1:0]          out_root [LANES],
  output logic [TAG_W-1:0]                out_tag
);

  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  // Stage registers, stage k holds k root bits
  logic                 vld  [1:ROOT_W];
  logic [TAG_W-1:0]     tag  [1:ROOT_W];
  logic [PAD_W-1:0]     rad  [1:ROOT_W][LANES];
  logic [REM_W-1:0]     rem  [1:ROOT_W][LANES];
  logic [ROOT_W-1:0]    root [1:ROOT_W][LANES];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              src_vld;
    logic [TAG_W-1:0]  src_tag;
    logic [PAD_W-1:0]  src_rad  [LANES];
    logic [REM_W-1:0]  src_rem  [LANES];
    logic [ROOT_W-1:0] src_root [LANES];
    logic [REM_W-1:0]  rem_sh   [LANES];
    logic [REM_W-1:0]  trial    [LANES];
    logic              ge       [LANES];

    // Stage source: ports for the first stage, previous registers after
    if (k == 0) begin : g_first
      always_comb begin
        src_vld = in_valid;
        src_tag = in_tag;
        for (int l = 0; l < LANES; l++) begin
          src_rad[l]  = PAD_W'(in_rad[l]);
          src_rem[l]  = '0;
          src_root[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        src_vld = vld[k];
        src_tag = tag[k];
        for (int l = 0; l < LANES; l++) begin
          src_rad[l]  = rad[k][l];
          src_rem[l]  = rem[k][l];
          src_root[l] = root[k][l];
        end
      end
    end

    // One restoring step: bring down two radicand bits, try root*4+1
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem_sh[l] = {src_rem[l][REM_W-3:0], src_rad[l][PAD_W-1 -: 2]};
        trial[l]  = {1'b0, src_root[l], 2'b01};
        ge[l]     = (rem_sh[l] >= trial[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= src_vld;
      end
      tag[k+1] <= src_tag;
      for (int l = 0; l < LANES; l++) begin
        rad[k+1][l]  <= src_rad[l] << 2;
        rem[k+1][l]  <= ge[l] ? (rem_sh[l] - trial[l]) : rem_sh[l];
        root[k+1][l] <= {src_root[l][ROOT_W-2:0], ge[l]};
      end
    end
  end

  // Last stage drives the outputs
  always_comb begin
    out_valid = vld[ROOT_W];
    out_tag   = tag[ROOT_W];
    for (int l = 0; l < LANES; l++) begin
      out_root[l] = root[ROOT_W][l];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/triangle_perimeter_area.sv */
// Triangle perimeter or Heron area, fully pipelined; one item per cycle.
// Stages: differences, squares, scaled sums, side roots, Heron factors,
// pairwise products, partial products, full product, area root, output reg.
// Throughput: one item every cycle; busy is high only during reset.
// Reset (synchronous, rst high) clears all valid bits; results cannot stall.
`default_nettype none

module triangle_perimeter_area
  import tpa_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         func,
  input  wire logic signed [COORD_BITS-1:0] first_x,
  input  wire logic signed [COORD_BITS-1:0] first_y,
  input  wire logic signed [COORD_BITS-1:0] second_x,
  input  wire logic signed [COORD_BITS-1:0] second_y,
  input  wire logic signed [COORD_BITS-1:0] third_x,
  input  wire logic signed [COORD_BITS-1:0] third_y,
  output logic                              done,
  output logic [RESULT_W-1:0]               result_value,
  output logic                              clamped
);

  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int SUM_W       = SQ_W + 1;
  localparam int SCALE_SHIFT = 2 * SIDE_FRAC - 2 * COORD_FRAC_BITS;
  localparam int RAD_W       = SUM_W + SCALE_SHIFT;
  localparam int SIDE_W      = (RAD_W + 1) / 2;
  localparam int F_W         = SIDE_W + 2;
  localparam int P_W         = 2 * F_W;
  localparam int PL_W        = P_W / 2;
  localparam int PH_W        = P_W - PL_W;
  localparam int PR_W        = 2 * P_W;
  localparam int AR_W        = PR_W - HERON_SHIFT;
  localparam int AROOT_W     = (AR_W + 1) / 2;

  assign busy = rst;

  logic accept;
  assign accept = start & ~busy;

  // Vertices as arrays; side i runs from vertex i to vertex (i+1) mod 3
  logic signed [COORD_BITS-1:0] vx [3];
  logic signed [COORD_BITS-1:0] vy [3];
  assign vx[0] = first_x;
  assign vx[1] = second_x;
  assign vx[2] = third_x;
  assign vy[0] = first_y;
  assign vy[1] = second_y;
  assign vy[2] = third_y;

  // Stage 1: absolute coordinate differences
  logic              s1_vld;
  logic              s1_func;
  logic [DIFF_W-1:0] s1_ax [3];
  logic [DIFF_W-1:0] s1_ay [3];
  logic [DIFF_W-1:0] ax_next [3];
  logic [DIFF_W-1:0] ay_next [3];

  for (genvar i = 0; i < 3; i++) begin : g_diff
    localparam int J = (i == 2) ? 0 : i + 1;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    always_comb begin
      dx = DIFF_W'(vx[i]) - DIFF_W'(vx[J]);
      dy = DIFF_W'(vy[i]) - DIFF_W'(vy[J]);
      ax_next[i] = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ay_next[i] = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
    s1_func <= func;
    for (int i = 0; i < 3; i++) begin
      s1_ax[i] <= ax_next[i];
      s1_ay[i] <= ay_next[i];
    end
  end

  // Stage 2: squares
  logic            s2_vld;
  logic            s2_func;
  logic [SQ_W-1:0] s2_sqx [3];
  logic [SQ_W-1:0] s2_sqy [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_func <= s1_func;
    for (int i = 0; i < 3; i++) begin
      s2_sqx[i] <= SQ_W'(s1_ax[i]) * SQ_W'(s1_ax[i]);
      s2_sqy[i] <= SQ_W'(s1_ay[i]) * SQ_W'(s1_ay[i]);
    end
  end

  // Stage 3: squared distance scaled to 2*SIDE_FRAC fraction bits
  logic             s3_vld;
  logic [0:0]       s3_func;
  logic [RAD_W-1:0] s3_rad [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_func <= s2_func;
    for (int i = 0; i < 3; i++) begin
      s3_rad[i] <= RAD_W'(SUM_W'(s2_sqx[i]) + SUM_W'(s2_sqy[i])) << SCALE_SHIFT;
    end
  end

  // Side lengths
  logic              side_vld;
  logic [0:0]        side_func;
  logic [SIDE_W-1:0] side_len [3];

  tpa_isqrt #(
    .RAD_W (RAD_W),
    .LANES (3),
    .TAG_W (1)
  ) u_side_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_vld),
    .in_rad    (s3_rad),
    .in_tag    (s3_func),
    .out_valid (side_vld),
    .out_root  (side_len),
    .out_tag   (side_func)
  );

  // Stage 4: Heron factors, perimeter and triangle-inequality check
  logic                   s4_vld;
  tpa_tag_t               s4_tag;
  logic [F_W-1:0]         s4_f [4];
  logic [F_W-1:0]         f_next [4];
  logic [F_W+RESULT_W-1:0] perim_ext;
  tpa_tag_t               tag4_next;
  logic                   neg;

  always_comb begin
    f_next[0] = F_W'(side_len[0]) + F_W'(side_len[1]) + F_W'(side_len[2]);
    f_next[1] = F_W'(side_len[1]) + F_W'(side_len[2]) - F_W'(side_len[0]);
    f_next[2] = F_W'(side_len[0]) + F_W'(side_len[2]) - F_W'(side_len[1]);
    f_next[3] = F_W'(side_len[0]) + F_W'(side_len[1]) - F_W'(side_len[2]);
    neg = f_next[1][F_W-1] | f_next[2][F_W-1] | f_next[3][F_W-1];
    perim_ext = (F_W+RESULT_W)'(f_next[0]);
    tag4_next.func  = side_func[0];
    tag4_next.clamp = (side_func[0] == OP_AREA) & neg;
    tag4_next.perim = (|perim_ext[F_W+RESULT_W-1:RESULT_W]) ? '1
                                                            : perim_ext[RESULT_W-1:0];
    // clamped area is forced to zero through the product
    if (tag4_next.clamp) begin
      for (int i = 0; i < 4; i++) begin
        f_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= side_vld;
    end
    s4_tag <= tag4_next;
    for (int i = 0; i < 4; i++) begin
      s4_f[i] <= f_next[i];
    end
  end

  // Stage 5: pairwise products
  logic           s5_vld;
  tpa_tag_t       s5_tag;
  logic [P_W-1:0] s5_p;
  logic [P_W-1:0] s5_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_tag <= s4_tag;
    s5_p   <= P_W'(s4_f[0]) * P_W'(s4_f[1]);
    s5_q   <= P_W'(s4_f[2]) * P_W'(s4_f[3]);
  end

  // Stage 6: partial products of p*q
  logic                 s6_vld;
  tpa_tag_t             s6_tag;
  logic [2*PH_W-1:0]    s6_hh;
  logic [PH_W+PL_W-1:0] s6_hl;
  logic [PH_W+PL_W-1:0] s6_lh;
  logic [2*PL_W-1:0]    s6_ll;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
    s6_tag <= s5_tag;
    s6_hh  <= (2*PH_W)'(s5_p[P_W-1:PL_W]) * (2*PH_W)'(s5_q[P_W-1:PL_W]);
    s6_hl  <= (PH_W+PL_W)'(s5_p[P_W-1:PL_W]) * (PH_W+PL_W)'(s5_q[PL_W-1:0]);
    s6_lh  <= (PH_W+PL_W)'(s5_p[PL_W-1:0]) * (PH_W+PL_W)'(s5_q[P_W-1:PL_W]);
    s6_ll  <= (2*PL_W)'(s5_p[PL_W-1:0]) * (2*PL_W)'(s5_q[PL_W-1:0]);
  end

  // Stage 7: full product, scaled down to area^2
  logic            s7_vld;
  tpa_tag_t        s7_tag;
  logic [AR_W-1:0] s7_rad [1];
  logic [PR_W-1:0] prod;

  always_comb begin
    prod = (PR_W'(s6_hh) << (2 * PL_W))
         + ((PR_W'(s6_hl) + PR_W'(s6_lh)) << PL_W)
         + PR_W'(s6_ll);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= s6_vld;
    end
    s7_tag    <= s6_tag;
    s7_rad[0] <= prod[PR_W-1:HERON_SHIFT];
  end

  // Area root
  logic               area_vld;
  tpa_tag_t           area_tag;
  logic [AROOT_W-1:0] area_root [1];

  tpa_isqrt #(
    .RAD_W (AR_W),
    .LANES (1),
    .TAG_W ($bits(tpa_tag_t))
  ) u_area_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s7_vld),
    .in_rad    (s7_rad),
    .in_tag    (s7_tag),
    .out_valid (area_vld),
    .out_root  (area_root),
    .out_tag   (area_tag)
  );

  // Output register: select, saturate
  logic [AROOT_W+RESULT_W-1:0] area_ext;
  logic [RESULT_W-1:0]         area_sat;

  always_comb begin
    area_ext = (AROOT_W+RESULT_W)'(area_root[0]);
    area_sat = (|area_ext[AROOT_W+RESULT_W-1:RESULT_W]) ? '1 : area_ext[RESULT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= area_vld;
    end
    result_value <= (area_tag.func == OP_AREA) ? area_sat : area_tag.perim;
    clamped      <= area_tag.clamp;
  end

endmodule

`default_nettype wire
